[sv/assert_macros.svh]
// assertion helpers for the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is held
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, off while reset is held
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// next-cycle implication, also checked through reset
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[sv/vdib_pkg.sv]
package vdib_pkg;

    localparam int WINDOW_DEPTH = 5;
    localparam int MAX_VERTICES = 65536;
    localparam int WORDS_FULL   = 9;
    localparam int WORDS_PLAIN  = 7;
    localparam int WORD_W       = 32;
    localparam int INDEX_W      = 16;

    localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
    localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
    localparam int POS_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

    localparam int PADDR_W = 3;
    localparam logic [PADDR_W-1:0] ADDR_HAS_TEXCOORDS = 3'd0;

    localparam logic [WORD_W-1:0] MAG_MASK = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] EXP_INF  = 32'h7F80_0000;

    typedef logic [WORDS_FULL-1:0][WORD_W-1:0] vertex_t;

    // float equality on raw bits: signed zeros match, nan never matches
    function automatic logic word_equal(input logic [WORD_W-1:0] a,
                                        input logic [WORD_W-1:0] b);
        logic [WORD_W-1:0] ma;
        logic [WORD_W-1:0] mb;
        logic result;
        ma = a & MAG_MASK;
        mb = b & MAG_MASK;
        if ((ma > EXP_INF) || (mb > EXP_INF)) begin
            result = 1'b0;
        end else if ((ma == '0) && (mb == '0)) begin
            result = 1'b1;
        end else begin
            result = (a == b);
        end
        return result;
    endfunction

endpackage

[sv/vertex_dedup_index_builder.sv]
// flow: a word accepted into the input stage is compared there and its result registered
//   into the output stage once that stage can take it (output empty or m_tready high)
// throughput: one vertex per cycle unless the output stalls; compare and update go together
// reset: aresetn low (synchronous) empties both stages, the window fill, the vertex count
//   and clears has_texcoords; window contents need no reset
module vertex_dedup_index_builder (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    // pos_x, pos_y, pos_z, col_r, col_g, col_b, col_a, tex_u, tex_v
    input  logic [vdib_pkg::WORDS_FULL*vdib_pkg::WORD_W-1:0] s_tdata,
    // start_buffer
    input  logic                                    s_tuser,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // vertex_index
    output logic [vdib_pkg::INDEX_W-1:0]            m_tdata,
    // is_new, overflow
    output logic [1:0]                              m_tuser,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [vdib_pkg::PADDR_W-1:0]            paddr,
    input  logic [31:0]                             pwdata,
    output logic [31:0]                             prdata,
    output logic                                    pready
);

    localparam int DEPTH = vdib_pkg::WINDOW_DEPTH;

    logic                                in_valid_reg;
    vdib_pkg::vertex_t                   in_words_reg;
    logic                                in_start_reg;
    logic                                out_valid_reg;
    logic [vdib_pkg::INDEX_W-1:0]        out_index_reg;
    logic                                out_new_reg;
    logic                                out_ovf_reg;
    vdib_pkg::vertex_t                   window_reg [DEPTH];
    logic [vdib_pkg::FILL_W-1:0]         fill_reg;
    logic [vdib_pkg::CNT_W-1:0]          count_reg;
    logic                                tex_reg;

    logic                                advance;
    logic [vdib_pkg::FILL_W-1:0]         fill_eff;
    logic [vdib_pkg::CNT_W-1:0]          count_eff;
    logic [DEPTH-1:0]                    match;
    logic                                found;
    logic [vdib_pkg::POS_W-1:0]          hit_pos;
    logic [31:0]                         hit_index;
    logic [31:0]                         count_wide;
    logic                                full;
    logic                                append;
    logic [vdib_pkg::FILL_W-1:0]         fill_next;
    logic [vdib_pkg::CNT_W-1:0]          count_next;
    logic [vdib_pkg::INDEX_W-1:0]        index_next;
    logic                                new_next;
    logic                                ovf_next;
    logic                                out_valid_next;
    logic                                cfg_write;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign fill_eff  = in_start_reg ? '0 : fill_reg;
    assign count_eff = in_start_reg ? '0 : count_reg;

    // newest entry sits at the top position, valid entries fill down from it
    always_comb begin
        logic entry_eq;
        for (int p = 0; p < DEPTH; p++) begin
            entry_eq = (32'(p) + 32'(fill_eff)) >= 32'(DEPTH);
            for (int k = 0; k < vdib_pkg::WORDS_FULL; k++) begin
                if ((k < vdib_pkg::WORDS_PLAIN) || tex_reg) begin
                    entry_eq = entry_eq &&
                               vdib_pkg::word_equal(in_words_reg[k], window_reg[p][k]);
                end
            end
            match[p] = entry_eq;
        end
    end

    // oldest match wins: lowest position
    always_comb begin
        found   = 1'b0;
        hit_pos = '0;
        for (int p = DEPTH - 1; p >= 0; p--) begin
            if (match[p]) begin
                found   = 1'b1;
                hit_pos = vdib_pkg::POS_W'(p);
            end
        end
    end

    assign count_wide = 32'(count_eff);
    assign hit_index  = count_wide + 32'(hit_pos) - 32'(DEPTH);
    assign full       = count_eff >= vdib_pkg::CNT_W'(vdib_pkg::MAX_VERTICES);
    assign append     = !found && !full;

    always_comb begin
        priority if (found) begin
            index_next = hit_index[vdib_pkg::INDEX_W-1:0];
            new_next   = 1'b0;
            ovf_next   = 1'b0;
        end else if (full) begin
            index_next = '0;
            new_next   = 1'b0;
            ovf_next   = 1'b1;
        end else begin
            index_next = count_wide[vdib_pkg::INDEX_W-1:0];
            new_next   = 1'b1;
            ovf_next   = 1'b0;
        end
    end

    always_comb begin
        fill_next  = fill_eff;
        count_next = count_eff;
        if (append) begin
            count_next = count_eff + 1'b1;
            if (fill_eff != vdib_pkg::FILL_W'(DEPTH)) begin
                fill_next = fill_eff + 1'b1;
            end
        end
    end

    assign out_valid_next = advance || (out_valid_reg && !m_tready);

    assign cfg_write = psel && penable && pwrite && pready &&
                       (paddr == vdib_pkg::ADDR_HAS_TEXCOORDS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fill_reg      <= '0;
            count_reg     <= '0;
            tex_reg       <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            out_valid_reg <= out_valid_next;
            if (advance) begin
                fill_reg  <= fill_next;
                count_reg <= count_next;
            end
            if (cfg_write) begin
                tex_reg <= pwdata[0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_words_reg <= s_tdata;
            in_start_reg <= s_tuser;
        end
        if (advance) begin
            out_index_reg <= index_next;
            out_new_reg   <= new_next;
            out_ovf_reg   <= ovf_next;
        end
        if (advance && append) begin
            for (int p = 0; p < DEPTH - 1; p++) begin
                window_reg[p] <= window_reg[p+1];
            end
            window_reg[DEPTH-1] <= in_words_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_index_reg;
    assign m_tuser  = {out_ovf_reg, out_new_reg};

    assign pready = 1'b1;
    assign prdata = (paddr == vdib_pkg::ADDR_HAS_TEXCOORDS) ? {31'b0, tex_reg} : 32'b0;

endmodule

[sv/vdib_checker.sv]
`include "assert_macros.svh"

module vdib_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tready,
    input logic [vdib_pkg::INDEX_W-1:0] m_tdata,
    input logic [1:0]                   m_tuser,
    input logic                         m_tvalid,
    input logic                         m_tready
);

    // stalled result word holds
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // an overflow word is never new and carries index zero
    `ASSERT_IMPLY(a_ovf_fields, aclk, aresetn, m_tvalid && m_tuser[1], !m_tuser[0] && (m_tdata == '0))

    // with the output stage empty the input side always takes a word
    `ASSERT_IMPLY(a_ready_when_empty, aclk, aresetn, !m_tvalid, s_tready)

    // reset empties the output stage
    `ASSERT_NEXT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_tvalid)

endmodule

bind vertex_dedup_index_builder vdib_checker u_vdib_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
